>>> hdl/iafs_pkg.sv
package iafs_pkg;

	localparam int unsigned IndexBits = 16;
	localparam int unsigned MaxRuns = 64;
	localparam int unsigned InitialCapacity = 1024;
	localparam int unsigned TopBits = IndexBits + 1;
	localparam int unsigned TotalBits = $clog2(MaxRuns + 1);

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic [1:0] POL_FAST = 2'd0;
	localparam logic [1:0] POL_FIT = 2'd1;
	localparam logic [1:0] POL_RECYCLE = 2'd2;
	localparam logic [1:0] POL_ALIAS = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_POP_HEAD,
		OP_REMOVE,
		OP_INSERT,
		OP_GROW_DOWN,
		OP_GROW_UP,
		OP_MERGE
	} op_t;

	typedef struct packed {
		logic [IndexBits-1:0] begin_v;
		logic [IndexBits-1:0] length_v;
	} run_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		op_t op;
		logic [TotalBits-1:0] pos;
		logic [IndexBits-1:0] ix;
	} cmd_t;

	// Per-cell compare flags.
	typedef struct packed {
		logic valid;
		logic covers;
		logic above;
		logic starts_next;
		logic ends_at;
	} flags_t;

endpackage

>>> hdl/iafs_if.sv
interface iafs_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [iafs_pkg::IndexBits-1:0] index;
	modport source(output valid, output func, output index, input ready);
	modport sink(input valid, input func, input index, output ready);
endinterface

interface iafs_out_if;
	logic valid;
	logic ready;
	logic [iafs_pkg::IndexBits-1:0] result_index;
	logic is_allocated;
	logic [1:0] status;
	modport source(output valid, output result_index, output is_allocated, output status,
		input ready);
	modport sink(input valid, input result_index, input is_allocated, input status,
		output ready);
endinterface

>>> hdl/iafs_cell.sv
module iafs_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [iafs_pkg::TotalBits-1:0] my_pos,
	input  logic [iafs_pkg::TotalBits-1:0] run_total,
	input  iafs_pkg::cmd_t cmd,
	input  logic cmd_en,
	input  iafs_pkg::run_t prev_run,
	input  iafs_pkg::run_t next_run,
	output iafs_pkg::run_t run,
	output iafs_pkg::flags_t flags
);
	iafs_pkg::run_t run_q;
	iafs_pkg::run_t run_d;
	logic [iafs_pkg::IndexBits:0] end_w;

	assign run = run_q;
	assign end_w = {1'b0, run_q.begin_v} + {1'b0, run_q.length_v};

	always_comb begin
		flags.valid = my_pos < run_total;
		flags.above = run_q.begin_v > cmd.ix;
		flags.covers = !flags.above && ({1'b0, cmd.ix} < end_w);
		flags.starts_next = {1'b0, run_q.begin_v} == {1'b0, cmd.ix} + 17'd1;
		flags.ends_at = end_w == {1'b0, cmd.ix};
	end

	always_comb begin
		run_d = run_q;
		case (cmd.op)
			iafs_pkg::OP_POP_HEAD: begin
				if (my_pos == cmd.pos) begin
					run_d.begin_v = run_q.begin_v + 1'b1;
					run_d.length_v = run_q.length_v - 1'b1;
				end
			end
			iafs_pkg::OP_REMOVE: begin
				if (my_pos >= cmd.pos) begin
					run_d = next_run;
				end
			end
			iafs_pkg::OP_INSERT: begin
				if (my_pos > cmd.pos) begin
					run_d = prev_run;
				end else if (my_pos == cmd.pos) begin
					run_d.begin_v = cmd.ix;
					run_d.length_v = {{(iafs_pkg::IndexBits-1){1'b0}}, 1'b1};
				end
			end
			iafs_pkg::OP_GROW_DOWN: begin
				if (my_pos == cmd.pos) begin
					run_d.begin_v = run_q.begin_v - 1'b1;
					run_d.length_v = run_q.length_v + 1'b1;
				end
			end
			iafs_pkg::OP_GROW_UP: begin
				if (my_pos == cmd.pos) begin
					run_d.length_v = run_q.length_v + 1'b1;
				end
			end
			iafs_pkg::OP_MERGE: begin
				if (my_pos == cmd.pos) begin
					run_d.length_v = run_q.length_v + 1'b1 + next_run.length_v;
				end else if (my_pos > cmd.pos) begin
					run_d = next_run;
				end
			end
			default: begin
				run_d = run_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd_en) begin
			run_q <= run_d;
		end
	end
endmodule

>>> hdl/iafs_chain.sv
module iafs_chain (
	input  logic clk,
	input  logic arst_n,
	input  logic [iafs_pkg::TotalBits-1:0] run_total,
	input  iafs_pkg::cmd_t cmd,
	input  logic cmd_en,
	output iafs_pkg::run_t head_run,
	output iafs_pkg::run_t last_run,
	output iafs_pkg::flags_t flags [iafs_pkg::MaxRuns]
);
	localparam int unsigned PosBits = iafs_pkg::TotalBits;
	iafs_pkg::run_t runs [iafs_pkg::MaxRuns];
	iafs_pkg::run_t zero_run;
	logic [PosBits-1:0] last_pos;

	assign zero_run = '0;
	assign head_run = runs[0];
	assign last_pos = run_total - 1'b1;
	assign last_run = runs[last_pos[$clog2(iafs_pkg::MaxRuns)-1:0]];

	for (genvar g = 0; g < iafs_pkg::MaxRuns; g++) begin : g_cell
		iafs_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.my_pos(PosBits'(g)),
			.run_total(run_total),
			.cmd(cmd),
			.cmd_en(cmd_en),
			.prev_run((g == 0) ? zero_run : runs[(g == 0) ? 0 : g - 1]),
			.next_run((g == iafs_pkg::MaxRuns - 1) ? zero_run
				: runs[(g == iafs_pkg::MaxRuns - 1) ? g : g + 1]),
			.run(runs[g]),
			.flags(flags[g])
		);
	end
endmodule

>>> hdl/index_allocator_free_segments_top.sv
// One request at a time: a beat is taken in idle, compared combinationally
// against all free runs of the cell chain, applied to the chain (a shift by
// one place for insert, remove and merge) the next cycle, and the result beat
// is shown the cycle after and held until the output is ready.
module index_allocator_free_segments_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_wdata,
	iafs_in_if.sink in_ch,
	iafs_out_if.source out_ch
);
	localparam int unsigned IB = iafs_pkg::IndexBits;
	localparam int unsigned NR = iafs_pkg::MaxRuns;
	localparam int unsigned TB = iafs_pkg::TotalBits;
	localparam int unsigned PB = $clog2(NR);

	iafs_pkg::state_t state_q, state_d;
	logic [1:0] policy_q;
	logic [1:0] func_q;
	logic [IB-1:0] ix_q;
	logic [iafs_pkg::TopBits-1:0] top_q;
	logic [iafs_pkg::TopBits-1:0] cap_q;
	logic [TB-1:0] total_q;
	iafs_pkg::cmd_t cmd_q;
	logic [IB-1:0] res_ix_q;
	logic alloc_q;
	logic [1:0] status_q;

	iafs_pkg::cmd_t cmd_w;
	iafs_pkg::run_t head_run, last_run;
	iafs_pkg::flags_t flags [NR];
	logic covered_w, have_above_w, have_match_w, match_down_w;
	logic [PB-1:0] above_pos_w, match_pos_w;
	logic [NR-1:0] above_vec, match_vec;
	logic apply_en;
	logic [1:0] pol_eff;

	logic [iafs_pkg::TopBits-1:0] top_d, cap_d;
	logic [TB-1:0] total_d;
	iafs_pkg::cmd_t cmd_d;
	logic [IB-1:0] res_ix_d;
	logic alloc_d;
	logic [1:0] status_d;
	logic [IB:0] last_end;
	logic [PB-1:0] ins_pos;

	assign cmd_w.op = iafs_pkg::OP_NONE;
	assign cmd_w.pos = '0;
	assign cmd_w.ix = ix_q;

	iafs_chain u_chain (
		.clk(clk),
		.arst_n(arst_n),
		.run_total(total_q),
		.cmd((state_q == iafs_pkg::S_APPLY) ? cmd_q : cmd_w),
		.cmd_en(apply_en),
		.head_run(head_run),
		.last_run(last_run),
		.flags(flags)
	);

	assign pol_eff = (policy_q == iafs_pkg::POL_ALIAS) ? iafs_pkg::POL_FIT : policy_q;

	always_comb begin
		covered_w = 1'b0;
		for (int k = 0; k < NR; k++) begin
			above_vec[k] = flags[k].valid && flags[k].above;
			match_vec[k] = flags[k].valid && (flags[k].starts_next || flags[k].ends_at);
			if (flags[k].valid && flags[k].covers) begin
				covered_w = 1'b1;
			end
		end
		have_above_w = |above_vec;
		have_match_w = |match_vec;
		above_pos_w = '0;
		match_pos_w = '0;
		for (int k = NR - 1; k >= 0; k--) begin
			if (above_vec[k]) begin
				above_pos_w = PB'(k);
			end
			if (match_vec[k]) begin
				match_pos_w = PB'(k);
			end
		end
		match_down_w = flags[match_pos_w].starts_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iafs_pkg::S_IDLE;
			policy_q <= iafs_pkg::POL_FIT;
			top_q <= '0;
			cap_q <= iafs_pkg::TopBits'(iafs_pkg::InitialCapacity);
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			if (state_q == iafs_pkg::S_EVAL) begin
				top_q <= top_d;
				cap_q <= cap_d;
				total_q <= total_d;
			end
		end
	end

	assign last_end = {1'b0, last_run.begin_v} + {1'b0, last_run.length_v};
	assign ins_pos = have_above_w ? above_pos_w : total_q[PB-1:0];

	always_comb begin
		top_d = top_q;
		cap_d = cap_q;
		total_d = total_q;
		cmd_d.op = iafs_pkg::OP_NONE;
		cmd_d.pos = '0;
		cmd_d.ix = ix_q;
		res_ix_d = '0;
		alloc_d = 1'b0;
		status_d = iafs_pkg::ST_OK;
		case (func_q)
			iafs_pkg::FUNC_ALLOC: begin
				if (pol_eff == iafs_pkg::POL_FAST || total_q == '0 ||
						(pol_eff == iafs_pkg::POL_RECYCLE && top_q < cap_q)) begin
					if (top_q[IB]) begin
						status_d = iafs_pkg::ST_EXHAUSTED;
					end else begin
						res_ix_d = top_q[IB-1:0];
						top_d = top_q + 1'b1;
					end
				end else begin
					res_ix_d = head_run.begin_v;
					if (head_run.length_v <= {{(IB-1){1'b0}}, 1'b1}) begin
						cmd_d.op = iafs_pkg::OP_REMOVE;
						total_d = total_q - 1'b1;
					end else begin
						cmd_d.op = iafs_pkg::OP_POP_HEAD;
					end
				end
				if (status_d == iafs_pkg::ST_OK && top_d > cap_q) begin
					cap_d = {cap_q[iafs_pkg::TopBits-2:0], 1'b0};
				end
			end
			iafs_pkg::FUNC_RELEASE: begin
				if ({1'b0, ix_q} >= top_q || covered_w) begin
					status_d = iafs_pkg::ST_IGNORED;
				end else if ({1'b0, ix_q} + 1'b1 == top_q) begin
					top_d = top_q - 1'b1;
					if (policy_q != iafs_pkg::POL_FAST && total_q != '0 &&
							last_end == {1'b0, ix_q}) begin
						top_d = {1'b0, last_run.begin_v};
						total_d = total_q - 1'b1;
					end
				end else if (policy_q == iafs_pkg::POL_FAST) begin
					status_d = iafs_pkg::ST_IGNORED;
				end else if (have_match_w && (!have_above_w || match_pos_w <= above_pos_w)) begin
					cmd_d.pos = TB'(match_pos_w);
					if (match_down_w) begin
						cmd_d.op = iafs_pkg::OP_GROW_DOWN;
					end else if ({1'b0, match_pos_w} + 1'b1 < total_q &&
							flags[(match_pos_w == PB'(NR - 1)) ? match_pos_w
							: match_pos_w + 1'b1].starts_next) begin
						cmd_d.op = iafs_pkg::OP_MERGE;
						total_d = total_q - 1'b1;
					end else begin
						cmd_d.op = iafs_pkg::OP_GROW_UP;
					end
				end else if (total_q >= TB'(NR)) begin
					status_d = iafs_pkg::ST_FULL;
				end else begin
					cmd_d.op = iafs_pkg::OP_INSERT;
					cmd_d.pos = TB'(ins_pos);
					total_d = total_q + 1'b1;
				end
			end
			iafs_pkg::FUNC_QUERY: begin
				alloc_d = ({1'b0, ix_q} < top_q) && !covered_w;
			end
			default: begin
				alloc_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			func_q <= in_ch.func;
			ix_q <= in_ch.index;
		end
		if (state_q == iafs_pkg::S_EVAL) begin
			cmd_q <= cmd_d;
			res_ix_q <= res_ix_d;
			alloc_q <= alloc_d;
			status_q <= status_d;
		end
	end

	assign apply_en = state_q == iafs_pkg::S_APPLY;
	assign in_ch.ready = state_q == iafs_pkg::S_IDLE;
	assign out_ch.valid = state_q == iafs_pkg::S_OUT;
	assign out_ch.result_index = res_ix_q;
	assign out_ch.is_allocated = alloc_q;
	assign out_ch.status = status_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			iafs_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					state_d = iafs_pkg::S_EVAL;
				end
			end
			iafs_pkg::S_EVAL: begin
				state_d = iafs_pkg::S_APPLY;
			end
			iafs_pkg::S_APPLY: begin
				state_d = iafs_pkg::S_OUT;
			end
			iafs_pkg::S_OUT: begin
				if (out_ch.ready) begin
					state_d = iafs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = iafs_pkg::S_IDLE;
			end
		endcase
	end
endmodule

>>> hdl/iafs_checker.sv
module iafs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_status,
	input logic out_is_allocated,
	input logic [iafs_pkg::IndexBits-1:0] out_result_index
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ##2 out_valid) else $error("result late");
	a_query_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_is_allocated) |->
		(out_status == iafs_pkg::ST_OK && out_result_index == '0))
		else $error("query result mixed");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_status))
		else $error("result dropped");
endmodule

bind index_allocator_free_segments_top iafs_checker u_iafs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_status(out_ch.status),
	.out_is_allocated(out_ch.is_allocated),
	.out_result_index(out_ch.result_index)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned SpaceSize = 1 << iafs_pkg::IndexBits;

	typedef struct {
		logic [iafs_pkg::IndexBits-1:0] granted;
		logic                           allocated;
		logic [1:0]                     status;
	} grant_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	iafs_in_if in_ch();
	iafs_out_if out_ch();

	index_allocator_free_segments_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	grant_t pending_grants[$];
	int error_count = 0;

	logic [1:0] cur_policy;
	int unsigned top_count;
	longint unsigned soft_capacity;
	int unsigned run_begin[iafs_pkg::MaxRuns];
	int unsigned run_length[iafs_pkg::MaxRuns];
	int unsigned run_total;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit inside_free_run(int unsigned ix);
		for (int unsigned k = 0; k < run_total; k++) begin
			if (run_begin[k] > ix)
				return 1'b0;
			if (ix < run_begin[k] + run_length[k])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void drop_run(int unsigned pos);
		for (int unsigned k = pos; k + 1 < run_total; k++) begin
			run_begin[k] = run_begin[k + 1];
			run_length[k] = run_length[k + 1];
		end
		run_total--;
	endfunction

	function automatic logic [1:0] open_run(int unsigned pos, int unsigned ix);
		if (run_total >= iafs_pkg::MaxRuns)
			return iafs_pkg::ST_FULL;
		for (int unsigned k = run_total; k > pos; k--) begin
			run_begin[k] = run_begin[k - 1];
			run_length[k] = run_length[k - 1];
		end
		run_begin[pos] = ix;
		run_length[pos] = 1;
		run_total++;
		return iafs_pkg::ST_OK;
	endfunction

	function automatic logic [1:0] take_index(output int unsigned granted);
		logic [1:0] pol;
		bit on_top;
		pol = (cur_policy == iafs_pkg::POL_ALIAS) ? iafs_pkg::POL_FIT : cur_policy;
		on_top = (pol == iafs_pkg::POL_FAST) || run_total == 0 ||
			(pol == iafs_pkg::POL_RECYCLE && top_count < soft_capacity);
		granted = 0;
		if (on_top) begin
			if (top_count >= SpaceSize)
				return iafs_pkg::ST_EXHAUSTED;
			granted = top_count;
			top_count++;
		end else begin
			granted = run_begin[0];
			if (run_length[0] <= 1) begin
				drop_run(0);
			end else begin
				run_begin[0]++;
				run_length[0]--;
			end
		end
		if (top_count > soft_capacity)
			soft_capacity = soft_capacity * 2;
		return iafs_pkg::ST_OK;
	endfunction

	function automatic logic [1:0] give_back(int unsigned ix);
		int unsigned last;
		if (ix >= top_count || inside_free_run(ix))
			return iafs_pkg::ST_IGNORED;
		if (ix + 1 == top_count) begin
			top_count--;
			if (cur_policy != iafs_pkg::POL_FAST && run_total > 0) begin
				last = run_total - 1;
				if (run_begin[last] + run_length[last] == ix) begin
					top_count = run_begin[last];
					run_total--;
				end
			end
			return iafs_pkg::ST_OK;
		end
		if (cur_policy == iafs_pkg::POL_FAST)
			return iafs_pkg::ST_IGNORED;
		for (int unsigned k = 0; k < run_total; k++) begin
			if (run_begin[k] == ix + 1) begin
				run_begin[k]--;
				run_length[k]++;
				return iafs_pkg::ST_OK;
			end
			if (run_begin[k] + run_length[k] == ix) begin
				if (k + 1 < run_total && run_begin[k + 1] == ix + 1) begin
					run_length[k] += 1 + run_length[k + 1];
					drop_run(k + 1);
				end else begin
					run_length[k]++;
				end
				return iafs_pkg::ST_OK;
			end
			if (run_begin[k] > ix)
				return open_run(k, ix);
		end
		return open_run(run_total, ix);
	endfunction

	function automatic grant_t predict_grant(logic [1:0] func,
			logic [iafs_pkg::IndexBits-1:0] ix);
		grant_t g;
		int unsigned granted;
		g.granted = '0;
		g.allocated = 1'b0;
		g.status = iafs_pkg::ST_OK;
		case (func)
			iafs_pkg::FUNC_ALLOC: begin
				g.status = take_index(granted);
				g.granted = granted[iafs_pkg::IndexBits-1:0];
			end
			iafs_pkg::FUNC_RELEASE: begin
				g.status = give_back(ix);
			end
			iafs_pkg::FUNC_QUERY: begin
				g.allocated = (ix < top_count) && !inside_free_run(ix);
			end
			default: begin
			end
		endcase
		return g;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 40));
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic send_request(logic [1:0] func, logic [iafs_pkg::IndexBits-1:0] ix);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.index <= ix;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_grants.push_back(predict_grant(func, ix));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_policy(logic [1:0] pol);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= pol;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_policy = pol;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = pending_grants[0];
				pending_grants.delete(0);
				if (out_ch.result_index !== want.granted)
					report_mismatch("result_index", int'(out_ch.result_index),
						int'(want.granted));
				if (out_ch.is_allocated !== want.allocated)
					report_mismatch("is_allocated", int'(out_ch.is_allocated),
						int'(want.allocated));
				if (out_ch.status !== want.status)
					report_mismatch("status", int'(out_ch.status), int'(want.status));
			end
		end
		if ($urandom_range(0, 99) < 70)
			out_ch.ready <= 1'b1;
		else
			out_ch.ready <= ($urandom_range(0, 19) == 0) ? 1'b1 : 1'b0;
	end

	task automatic test_directed();
		repeat (8) send_request(iafs_pkg::FUNC_ALLOC, '0);
		send_request(iafs_pkg::FUNC_QUERY, 16'd0);
		send_request(iafs_pkg::FUNC_QUERY, 16'd7);
		send_request(iafs_pkg::FUNC_QUERY, 16'd8);
		send_request(iafs_pkg::FUNC_QUERY, 16'hFFFF);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd3);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd3);
		send_request(iafs_pkg::FUNC_QUERY, 16'd3);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd5);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd4);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd1);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd7);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd6);
		send_request(iafs_pkg::FUNC_RELEASE, 16'hFFFF);
		send_request(iafs_pkg::FUNC_NONE, 16'hFFFF);
		send_request(iafs_pkg::FUNC_ALLOC, 16'hFFFF);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
	endtask

	task automatic test_run_table_full();
		set_policy(iafs_pkg::POL_FIT);
		repeat (140) send_request(iafs_pkg::FUNC_ALLOC, '0);
		for (int i = 0; i < 2 * (iafs_pkg::MaxRuns + 3); i += 2)
			send_request(iafs_pkg::FUNC_RELEASE, i[iafs_pkg::IndexBits-1:0]);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		for (int i = 0; i < 140; i++)
			send_request(iafs_pkg::FUNC_RELEASE, i[iafs_pkg::IndexBits-1:0]);
		drain();
	endtask

	task automatic test_random_policy(logic [1:0] pol, int count);
		int unsigned r;
		int unsigned pick;
		logic [iafs_pkg::IndexBits-1:0] ix;
		set_policy(pol);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 15) == 0)
				pick = $urandom_range(0, SpaceSize - 1);
			else if (pol == iafs_pkg::POL_FAST && $urandom_range(0, 1) == 0 && top_count > 0)
				pick = top_count - 1;
			else
				pick = $urandom_range(0, top_count + 3);
			ix = pick[iafs_pkg::IndexBits-1:0];
			if (r < 45)
				send_request(iafs_pkg::FUNC_ALLOC, ix);
			else if (r < 85)
				send_request(iafs_pkg::FUNC_RELEASE, ix);
			else if (r < 97)
				send_request(iafs_pkg::FUNC_QUERY, ix);
			else
				send_request(iafs_pkg::FUNC_NONE, ix);
			if (i == count / 2)
				drain();
		end
	endtask

	task automatic test_recycle_reuse();
		set_policy(iafs_pkg::POL_RECYCLE);
		repeat (5) send_request(iafs_pkg::FUNC_ALLOC, '0);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd0);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		set_policy(iafs_pkg::POL_FAST);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		send_request(iafs_pkg::FUNC_QUERY, 16'hFFFF);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd100);
		send_request(iafs_pkg::FUNC_RELEASE, 16'hFFFF);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		set_policy(iafs_pkg::POL_RECYCLE);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd100);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd102);
		send_request(iafs_pkg::FUNC_RELEASE, 16'd101);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		send_request(iafs_pkg::FUNC_ALLOC, '0);
		send_request(iafs_pkg::FUNC_QUERY, 16'd100);
		send_request(iafs_pkg::FUNC_QUERY, 16'd102);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = iafs_pkg::FUNC_ALLOC;
		in_ch.index = '0;
		out_ch.ready = 1'b0;
		cur_policy = iafs_pkg::POL_FIT;
		top_count = 0;
		soft_capacity = iafs_pkg::InitialCapacity;
		run_total = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_run_table_full();
		test_random_policy(iafs_pkg::POL_FIT, 300);
		test_random_policy(iafs_pkg::POL_RECYCLE, 250);
		test_random_policy(iafs_pkg::POL_FAST, 250);
		test_random_policy(iafs_pkg::POL_ALIAS, 250);
		test_recycle_reuse();
		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_grants.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
hdl/iafs_pkg.sv
hdl/iafs_if.sv
hdl/iafs_cell.sv
hdl/iafs_chain.sv
hdl/index_allocator_free_segments_top.sv
hdl/iafs_checker.sv
bench/tb.sv
